>>> rtl/i2c_srf_pkg.sv
package i2c_srf_pkg;

    // Field widths
    localparam int CMD_W     = 3;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int PHASE_W   = 2;

    // Bus event codes
    localparam logic [CMD_W-1:0] CMD_ADDR_WR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DATA_RX = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADDR_RD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TX_ACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TX_NACK = 3'd5;
    localparam logic [CMD_W-1:0] CMD_BUS_ERR = 3'd6;
    localparam logic [CMD_W-1:0] CMD_OTHER   = 3'd7;

    // Bus phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE      = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ADDRESSED = 2'd1;
    localparam logic [PHASE_W-1:0] PH_POINTER   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COPY_BASE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READY_BASE   = 2'd2;

    // Reset values of the base registers
    localparam logic [BYTE_W-1:0] COMMAND_BASE_RST = 8'd0;
    localparam logic [BYTE_W-1:0] COPY_BASE_RST    = 8'd3;
    localparam logic [BYTE_W-1:0] READY_BASE_RST   = 8'd6;

    // Number of command, copy and ready slots
    localparam int SLOT_COUNT = 3;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [PHASE_W-1:0] phase_t;

endpackage

>>> rtl/i2c_srf_in_if.sv
interface i2c_srf_in_if;
    import i2c_srf_pkg::*;

    logic  valid;
    logic  ready;
    cmd_t  cmd;
    byte_t rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

>>> rtl/i2c_srf_out_if.sv
interface i2c_srf_out_if;
    import i2c_srf_pkg::*;

    logic  valid;
    logic  ready;
    byte_t tx_byte;
    logic  acknowledge;
    logic  release_bus;
    logic  pointer_loaded;
    logic  write_done;
    logic  write_refused;
    logic  read_out_of_range;

    modport source (
        output valid, output tx_byte, output acknowledge, output release_bus,
        output pointer_loaded, output write_done, output write_refused,
        output read_out_of_range, input ready
    );
    modport sink (
        input valid, input tx_byte, input acknowledge, input release_bus,
        input pointer_loaded, input write_done, input write_refused,
        input read_out_of_range, output ready
    );
endinterface

>>> rtl/i2c_srf_cfg_if.sv
interface i2c_srf_cfg_if;
    import i2c_srf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    byte_t                data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink (input valid, input reg_index, input data, output ready);
endinterface

>>> rtl/i2c_slave_register_file.sv
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    cmd[2:0], rx_byte[7:0]
// out_ch    out  valid/ready    tx_byte[7:0], acknowledge, release_bus, pointer_loaded,
//                               write_done, write_refused, read_out_of_range
// cfg_ch    in   valid, ready=1 reg_index[1:0], data[7:0]
//
// One request per clock while out_ch takes results; a request passes through the input
// register, then the result register, and the store, pointer and phase update as the
// request moves into the result register. A stalled result holds the result register; an
// empty input register takes one more request and then holds it with in_ch.ready low.
// Reset (rst_n low, asynchronous) empties both registers, idles the phase, zeroes the
// pointer and clears the store except the three ready flags, which load one.
module i2c_slave_register_file #(
    parameter int REG_COUNT = 32
) (
    input logic           clk,
    input logic           rst_n,
    i2c_srf_in_if.sink    in_ch,
    i2c_srf_out_if.source out_ch,
    i2c_srf_cfg_if.sink   cfg_ch
);
    import i2c_srf_pkg::*;

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int AW    = BYTE_W + 1;

    // Input register
    logic  s1_valid_reg;
    cmd_t  s1_cmd_reg;
    byte_t s1_rx_reg;

    // Result register
    logic  out_valid_reg;
    byte_t tx_reg;
    logic  ack_reg, rel_reg, loaded_reg, done_reg, refused_reg, oor_reg;

    // Architectural state
    byte_t  command_base_reg, copy_base_reg, ready_base_reg;
    phase_t phase_reg, phase_next;
    byte_t  pointer_reg, pointer_next;
    byte_t  store_reg [REG_COUNT];

    // Per-request decode
    logic          advance;
    logic [AW-1:0] p_w, cmd_b, copy_b, ready_b;
    logic          in_cmd, in_copy, p_in_store;
    logic          wr_store, slot_hit;
    logic [1:0]    slot_k;
    logic [AW-1:0] ready_addr, copy_addr;
    byte_t         copy_val;
    byte_t         rd_byte, wrap_ptr;
    byte_t         tx_next;
    logic          ack_next, rel_next, loaded_next, done_next, refused_next, oor_next;
    byte_t         wrap_tab [256];

    assign advance = s1_valid_reg && (!out_valid_reg || out_ch.ready);

    assign in_ch.ready  = !s1_valid_reg || advance;
    assign cfg_ch.ready = 1'b1;

    // Pointer increment table: (p + 1) mod REG_COUNT
    for (genvar g = 0; g < 256; g++) begin : g_wrap
        localparam int unsigned WV = (g + 1) % REG_COUNT;
        assign wrap_tab[g] = BYTE_W'(WV);
    end

    // Hold the request in the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_cmd_reg <= in_ch.cmd;
            s1_rx_reg  <= in_ch.rx_byte;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_base_reg <= COMMAND_BASE_RST;
            copy_base_reg    <= COPY_BASE_RST;
            ready_base_reg   <= READY_BASE_RST;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.reg_index)
                CFG_COMMAND_BASE: command_base_reg <= cfg_ch.data;
                CFG_COPY_BASE:    copy_base_reg    <= cfg_ch.data;
                CFG_READY_BASE:   ready_base_reg   <= cfg_ch.data;
                default:          ;
            endcase
        end
    end

    // Decode slot windows and the matching command slot
    always_comb
    begin
        p_w     = {1'b0, pointer_reg};
        cmd_b   = {1'b0, command_base_reg};
        copy_b  = {1'b0, copy_base_reg};
        ready_b = {1'b0, ready_base_reg};

        in_cmd     = (p_w >= cmd_b) && (p_w <= cmd_b + AW'(2));
        in_copy    = (p_w >= copy_b) && (p_w <= copy_b + AW'(2));
        p_in_store = p_w < AW'(REG_COUNT);

        slot_hit = 1'b1;
        slot_k   = 2'd0;
        if (p_w == cmd_b)
        begin
            slot_k = 2'd0;
        end
        else if (p_w == cmd_b + AW'(1))
        begin
            slot_k = 2'd1;
        end
        else if (p_w == cmd_b + AW'(2))
        begin
            slot_k = 2'd2;
        end
        else
        begin
            slot_hit = 1'b0;
        end

        ready_addr = ready_b + AW'(slot_k);
        copy_addr  = copy_b + AW'(slot_k);
        // The copy slot takes the new byte unless the ready clear hit the written entry
        copy_val   = (ready_addr == p_w) ? '0 : s1_rx_reg;

        rd_byte  = p_in_store ? store_reg[pointer_reg[IDX_W-1:0]] : '0;
        wrap_ptr = wrap_tab[pointer_reg];
    end

    // Work out the result and the next phase and pointer
    always_comb
    begin
        phase_next   = phase_reg;
        pointer_next = pointer_reg;
        wr_store     = 1'b0;
        tx_next      = '0;
        ack_next     = 1'b1;
        rel_next     = 1'b0;
        loaded_next  = 1'b0;
        done_next    = 1'b0;
        refused_next = 1'b0;
        oor_next     = 1'b0;

        case (s1_cmd_reg)
            CMD_ADDR_WR:
            begin
                phase_next = PH_ADDRESSED;
            end
            CMD_DATA_RX:
            begin
                if (phase_reg == PH_ADDRESSED)
                begin
                    pointer_next = s1_rx_reg;
                    phase_next   = PH_POINTER;
                    loaded_next  = 1'b1;
                end
                else if (phase_reg == PH_POINTER)
                begin
                    if ((in_cmd || in_copy) && p_in_store)
                    begin
                        wr_store     = 1'b1;
                        pointer_next = wrap_ptr;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        refused_next = 1'b1;
                    end
                end
                else
                begin
                    ack_next = 1'b0;
                end
            end
            CMD_STOP, CMD_TX_NACK:
            begin
                phase_next = PH_IDLE;
            end
            CMD_ADDR_RD, CMD_TX_ACK:
            begin
                tx_next      = rd_byte;
                oor_next     = !p_in_store;
                pointer_next = wrap_ptr;
                phase_next   = PH_ADDRESSED;
            end
            default:
            begin
                phase_next = PH_IDLE;
                rel_next   = 1'b1;
            end
        endcase
    end

    // Advance phase and pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            pointer_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            pointer_reg <= pointer_next;
        end
    end

    // Update store entries: byte first, then ready clear, then command copy
    for (genvar i = 0; i < REG_COUNT; i++) begin : g_store
        localparam logic [AW-1:0] ENTRY = AW'(i);
        localparam logic RST_ONE = (i >= int'(READY_BASE_RST)) &&
                                   (i < int'(READY_BASE_RST) + SLOT_COUNT);
        byte_t entry_next;

        always_comb
        begin
            entry_next = store_reg[i];
            if (wr_store && (p_w == ENTRY))
            begin
                entry_next = s1_rx_reg;
            end
            if (wr_store && slot_hit && (ready_addr == ENTRY))
            begin
                entry_next = '0;
            end
            if (wr_store && slot_hit && (copy_addr == ENTRY))
            begin
                entry_next = copy_val;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                store_reg[i] <= BYTE_W'(RST_ONE);
            end
            else if (advance)
            begin
                store_reg[i] <= entry_next;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx_reg      <= tx_next;
            ack_reg     <= ack_next;
            rel_reg     <= rel_next;
            loaded_reg  <= loaded_next;
            done_reg    <= done_next;
            refused_reg <= refused_next;
            oor_reg     <= oor_next;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.tx_byte           = tx_reg;
    assign out_ch.acknowledge       = ack_reg;
    assign out_ch.release_bus       = rel_reg;
    assign out_ch.pointer_loaded    = loaded_reg;
    assign out_ch.write_done        = done_reg;
    assign out_ch.write_refused     = refused_reg;
    assign out_ch.read_out_of_range = oor_reg;

    // A stored byte is never also refused
    a_done_xor_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(done_reg && refused_reg))
        else $error("write_done and write_refused both set");

    // A pointer load takes the received byte
    a_pointer_load: assert property (@(posedge clk) disable iff (!rst_n)
        advance && loaded_next |=> pointer_reg == $past(s1_rx_reg))
        else $error("pointer not loaded from received byte");

    // Bus release always returns the phase to idle
    a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rel_next |=> phase_reg == PH_IDLE)
        else $error("phase not idle after bus release");

    // A request that cannot advance stays in the input register
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_cmd_reg)
                                     && $stable(s1_rx_reg))
        else $error("input register lost a pending request");

endmodule
